>>> sv/mew_pkg.sv
// Shared widths, types and register codes of the midpoint ellipse walker.
`timescale 1ns / 1ps

package mew_pkg;

    // coordinate width; all other widths follow from it
    localparam int COORD_BITS = 11;
    localparam int CW         = COORD_BITS;
    localparam int SQ_W       = 2 * CW;          // a^2, b^2
    localparam int OP_W       = 2 * CW + 2;      // widest operand: (2x+1)^2
    localparam int PROD_W     = 2 * OP_W;
    localparam int DEC_W      = 4 * CW + 12;     // decision variable, two's complement

    // APB side
    localparam int CFG_DW     = 32;
    localparam int CFG_AW     = 3;
    localparam int REG_IDX_W  = CFG_AW - 2;

    typedef logic [CW-1:0]        t_coord;
    typedef logic [SQ_W-1:0]      t_sq;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [DEC_W-1:0]     t_dec;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // register map
    localparam t_reg_idx REG_SEMI_A = t_reg_idx'(0);
    localparam t_reg_idx REG_SEMI_B = t_reg_idx'(1);

    // request to the shared multiplier
    typedef struct packed {
        logic en;
        t_op  op_a;
        t_op  op_b;
    } t_mul_req;

endpackage

>>> sv/mew_if.sv
// Request and point channel interfaces of the ellipse walker.
`timescale 1ns / 1ps

interface mew_req_if;
    import mew_pkg::*;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface mew_pt_if;
    import mew_pkg::*;

    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   in_second_region;
    logic   last_point;

    modport source (output valid, output point_x, output point_y,
                    output in_second_region, output last_point, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input in_second_region, input last_point, output ready);
endinterface

>>> sv/mew_mul.sv
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module mew_mul (
    input  logic              i_clk,
    input  mew_pkg::t_mul_req i_req,
    output mew_pkg::t_prod    o_prod
);
    import mew_pkg::*;

    t_prod r_prod;

    // product holds until the next issued operation
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= t_prod'(i_req.op_a) * t_prod'(i_req.op_b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> sv/midpoint_ellipse_quadrant_walker_unit.sv
// Midpoint ellipse quadrant walker: APB registers, step sequencer, output register.
//
// Usage: write semi_axis_a (offset 0x0) and semi_axis_b (offset 0x4) over APB
// while the walker is idle. Each beat on i_req asks for one point: restart=1
// squares the axes and begins at (0,b), restart=0 moves to the next point.
// A request yields at most one beat on o_pt; an advance after the quadrant
// is finished (or before any restart, or a restart with b=0) yields none.
// Every product of a step goes through the single 24x24 multiplier, one per
// cycle, and the decision update follows. A restart first squares a and b
// and forms a^2*b. The walker takes no new request until its step is done.
// The result lands in an output register; i_req is taken again while that
// beat waits, and a following result waits in its last step until the
// register frees up. A stalled receiver therefore holds the walker after
// at most one further result. Synchronous active-low reset: config clears
// to zero, the walk is marked finished, nothing is pending on o_pt.
`timescale 1ns / 1ps

module midpoint_ellipse_quadrant_walker_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [mew_pkg::CFG_AW-1:0] paddr,
    input  logic [mew_pkg::CFG_DW-1:0] pwdata,
    output logic [mew_pkg::CFG_DW-1:0] prdata,
    output logic                   pready,
    // channels
    mew_req_if.sink                i_req,
    mew_pt_if.source               o_pt
);
    import mew_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE    = 18'b000000000000000001,
        ST_RS_A    = 18'b000000000000000010,
        ST_RS_B    = 18'b000000000000000100,
        ST_RS_C    = 18'b000000000000001000,
        ST_RS_D    = 18'b000000000000010000,
        ST_R1_P1   = 18'b000000000000100000,
        ST_R1_P2   = 18'b000000000001000000,
        ST_R1_CMP  = 18'b000000000010000000,
        ST_R1_UPD  = 18'b000000000100000000,
        ST_R2E_TY  = 18'b000000001000000000,
        ST_R2E_BT  = 18'b000000010000000000,
        ST_R2E_AT  = 18'b000000100000000000,
        ST_R2E_AB  = 18'b000001000000000000,
        ST_R2E_FIN = 18'b000010000000000000,
        ST_R2_CHK  = 18'b000100000000000000,
        ST_R2_MX   = 18'b001000000000000000,
        ST_R2_UPD  = 18'b010000000000000000,
        ST_SPARE   = 18'b100000000000000000
    } t_state;

    // config
    t_coord   r_semi_a;
    t_coord   r_semi_b;
    logic     w_cfg_wr;
    t_reg_idx w_reg_idx;

    // walk state
    t_state   r_state;
    t_state   n_state;
    t_sq      r_a_sq;
    t_sq      r_b_sq;
    t_coord   r_x;
    t_coord   r_y;
    t_dec     r_dec;
    logic     r_region;
    logic     r_done;
    t_prod    r_tmp;

    // output register
    logic     r_out_valid;
    t_coord   r_out_x;
    t_coord   r_out_y;
    logic     r_out_reg2;
    logic     r_out_last;

    // datapath helpers
    t_mul_req w_mul;
    t_prod    w_prod;
    logic     w_in_acc;
    logic     w_out_free;
    logic     w_load;
    logic     w_dec_neg;
    logic     w_r1_holds;
    logic [CW:0]   w_x_inc;
    logic [CW+1:0] w_2x3;
    logic [CW:0]   w_tx;
    logic [CW:0]   w_2y1;
    t_coord   w_ty;
    t_coord   w_y_dec;
    t_dec     w_a_sq_d;
    t_dec     w_b_sq_d;
    t_dec     w_prod_d;
    t_dec     w_tmp_d;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_semi_a <= '0;
            r_semi_b <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_SEMI_A: r_semi_a <= pwdata[CW-1:0];
                REG_SEMI_B: r_semi_b <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_SEMI_A: prdata = CFG_DW'(r_semi_a);
            REG_SEMI_B: prdata = CFG_DW'(r_semi_b);
            default:    prdata = '0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    mew_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul),
        .o_prod (w_prod)
    );

    // small coordinate terms
    assign w_x_inc  = (CW+1)'(r_x) + (CW+1)'(1);
    assign w_2x3    = (CW+2)'({r_x, 1'b0}) + (CW+2)'(3);
    assign w_tx     = {r_x, 1'b1};
    assign w_2y1    = {r_y, 1'b0} - (CW+1)'(1);
    assign w_y_dec  = r_y - t_coord'(1);
    assign w_ty     = (r_y == '0) ? t_coord'(1) : w_y_dec;

    assign w_a_sq_d = t_dec'(r_a_sq);
    assign w_b_sq_d = t_dec'(r_b_sq);
    assign w_prod_d = t_dec'(w_prod);
    assign w_tmp_d  = t_dec'(r_tmp);
    assign w_dec_neg = r_dec[DEC_W-1];

    // region one continues while 2*b^2*(x+1) < a^2*(2y-1); r_tmp holds the left product
    assign w_r1_holds = (r_y != '0) && ({r_tmp, 1'b0} < {1'b0, w_prod});

    // operand select per step
    always_comb begin
        w_mul.en   = 1'b1;
        w_mul.op_a = '0;
        w_mul.op_b = '0;
        unique case (r_state)
            ST_RS_A: begin
                w_mul.op_a = t_op'(r_semi_a);
                w_mul.op_b = t_op'(r_semi_a);
            end
            ST_RS_B: begin
                w_mul.op_a = t_op'(r_semi_b);
                w_mul.op_b = t_op'(r_semi_b);
            end
            ST_RS_C: begin
                w_mul.op_a = t_op'(r_a_sq);
                w_mul.op_b = t_op'(r_semi_b);
            end
            ST_R1_P1, ST_R2_MX: begin
                w_mul.op_a = t_op'(r_b_sq);
                w_mul.op_b = t_op'(w_x_inc);
            end
            ST_R1_P2, ST_R2_CHK: begin
                w_mul.op_a = t_op'(r_a_sq);
                w_mul.op_b = t_op'(w_2y1);
            end
            ST_R1_CMP: begin
                if (w_r1_holds) begin
                    w_mul.op_a = t_op'(r_b_sq);
                    w_mul.op_b = t_op'(w_2x3);
                end else begin
                    w_mul.op_a = t_op'(w_tx);
                    w_mul.op_b = t_op'(w_tx);
                end
            end
            ST_R2E_TY: begin
                w_mul.op_a = t_op'(w_ty);
                w_mul.op_b = t_op'(w_ty);
            end
            ST_R2E_BT: begin
                w_mul.op_a = t_op'(r_a_sq);
                w_mul.op_b = w_prod[OP_W-1:0];
            end
            ST_R2E_AT: begin
                w_mul.op_a = t_op'(r_b_sq);
                w_mul.op_b = r_tmp[OP_W-1:0];
            end
            ST_R2E_AB: begin
                w_mul.op_a = t_op'(r_a_sq);
                w_mul.op_b = t_op'(r_b_sq);
            end
            default: begin
                w_mul.en = 1'b0;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_pt.ready;
    assign w_load     = ((r_state == ST_R1_UPD) || (r_state == ST_R2_UPD)) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_req.restart)  n_state = ST_RS_A;
                    else if (r_done)    n_state = ST_IDLE;
                    else if (!r_region) n_state = ST_R1_P1;
                    else                n_state = ST_R2_CHK;
                end
            end
            ST_RS_A:    n_state = ST_RS_B;
            ST_RS_B:    n_state = ST_RS_C;
            ST_RS_C:    n_state = ST_RS_D;
            ST_RS_D:    n_state = ST_R1_P1;
            ST_R1_P1:   n_state = ST_R1_P2;
            ST_R1_P2:   n_state = ST_R1_CMP;
            ST_R1_CMP:  n_state = w_r1_holds ? ST_R1_UPD : ST_R2E_TY;
            ST_R1_UPD:  n_state = w_out_free ? ST_IDLE : ST_R1_UPD;
            ST_R2E_TY:  n_state = ST_R2E_BT;
            ST_R2E_BT:  n_state = ST_R2E_AT;
            ST_R2E_AT:  n_state = ST_R2E_AB;
            ST_R2E_AB:  n_state = ST_R2E_FIN;
            ST_R2E_FIN: n_state = ST_R2_CHK;
            ST_R2_CHK:  n_state = (r_y == '0) ? ST_IDLE : ST_R2_MX;
            ST_R2_MX:   n_state = ST_R2_UPD;
            ST_R2_UPD:  n_state = w_out_free ? ST_IDLE : ST_R2_UPD;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control flags of the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= 1'b0;
            r_done   <= 1'b1;
        end else begin
            unique case (r_state)
                ST_RS_C: begin
                    r_region <= 1'b0;
                    r_done   <= 1'b0;
                end
                ST_R2E_FIN: r_region <= 1'b1;
                ST_R2_CHK: begin
                    if (r_y == '0) r_done <= 1'b1;
                end
                ST_R2_UPD: begin
                    if (w_out_free && (w_y_dec == '0)) r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // walk datapath: squares, position, decision, scratch product
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_RS_B: r_a_sq <= w_prod[SQ_W-1:0];
            ST_RS_C: begin
                r_b_sq <= w_prod[SQ_W-1:0];
                r_x    <= '0;
                r_y    <= r_semi_b;
            end
            ST_RS_D: begin
                // 4b^2 + a^2 - 4a^2*b
                r_dec <= (w_b_sq_d << 2) + w_a_sq_d - (w_prod_d << 2);
            end
            ST_R1_P2, ST_R1_CMP, ST_R2E_TY, ST_R2_MX: r_tmp <= w_prod;
            ST_R1_UPD: begin
                if (w_out_free) begin
                    r_x <= w_x_inc[CW-1:0];
                    if (w_dec_neg) begin
                        r_dec <= r_dec + (w_prod_d << 2);
                    end else begin
                        // 8a^2 - 8a^2*y expressed through a^2*(2y-1)
                        r_dec <= r_dec + (w_prod_d << 2) + (w_a_sq_d << 2) - (w_tmp_d << 2);
                        r_y   <= w_y_dec;
                    end
                end
            end
            ST_R2E_AT:  r_dec <= w_prod_d << 2;
            ST_R2E_AB:  r_dec <= r_dec + w_prod_d;
            ST_R2E_FIN: r_dec <= r_dec - (w_prod_d << 2);
            ST_R2_UPD: begin
                if (w_out_free) begin
                    r_y <= w_y_dec;
                    if (w_dec_neg) begin
                        r_dec <= r_dec + (w_prod_d << 3) + (w_a_sq_d << 3) - (w_tmp_d << 2);
                        r_x   <= w_x_inc[CW-1:0];
                    end else begin
                        r_dec <= r_dec + (w_a_sq_d << 3) - (w_tmp_d << 2);
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_pt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // region one shows the point before its step, region two after
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_state == ST_R1_UPD) begin
                r_out_x    <= r_x;
                r_out_y    <= r_y;
                r_out_reg2 <= 1'b0;
                r_out_last <= (r_y == '0);
            end else begin
                r_out_x    <= w_dec_neg ? w_x_inc[CW-1:0] : r_x;
                r_out_y    <= w_y_dec;
                r_out_reg2 <= 1'b1;
                r_out_last <= (w_y_dec == '0);
            end
        end
    end

    assign i_req.ready           = (r_state == ST_IDLE);
    assign o_pt.valid            = r_out_valid;
    assign o_pt.point_x          = r_out_x;
    assign o_pt.point_y          = r_out_y;
    assign o_pt.in_second_region = r_out_reg2;
    assign o_pt.last_point       = r_out_last;

    // ---------------- assertions ----------------
    // a new beat only comes out of one of the two update steps
    a_out_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
            ($past(r_state) == ST_R1_UPD) || ($past(r_state) == ST_R2_UPD))
        else $error("output beat without an update step");

    // region one never steps from the x axis
    a_r1_y_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R1_UPD) |-> (r_y != '0))
        else $error("region one update with y at zero");

    // every region-two point moves down by one row
    a_r2_y_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R2_UPD) && w_out_free |=> (r_y == t_coord'($past(r_y) - t_coord'(1))))
        else $error("region two step did not lower y by one");

    // an advance on a finished walk produces nothing and stays idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && w_in_acc && !i_req.restart && r_done |=>
            (r_state == ST_IDLE) && !$rose(r_out_valid))
        else $error("finished walk started work");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the midpoint ellipse quadrant walker.
`timescale 1ns / 1ps

module tb_top;
    import mew_pkg::*;

    localparam int SETTLE_CYCLES   = 24;    // quiet time after every expected point has arrived
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int PLAN_ROWS       = 33;
    localparam int TX_IDLE_PCT [4] = '{0, 65, 0, 36};
    localparam int RX_STALL_PCT [4] = '{0, 0, 65, 36};

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   region2;
        logic   last;
    } t_point;

    localparam t_point NO_POINT = '0;

    typedef enum {ROW_REQ, ROW_WRITE_A, ROW_WRITE_B} t_row_kind;
    typedef enum {CHK_PREDICT, CHK_NONE, CHK_FIXED} t_check_kind;

    typedef struct {
        t_row_kind   kind;
        int unsigned value;
        bit          restart;
        t_check_kind chk;
        t_point      pt;
    } t_row;

    // directed stimulus: register writes and requests, in order
    t_row plan [PLAN_ROWS] = '{
        '{ROW_REQ,     0,    1'b0, CHK_NONE,    NO_POINT},  // advance before any restart
        '{ROW_REQ,     0,    1'b1, CHK_NONE,    NO_POINT},  // restart with b zero
        '{ROW_WRITE_B, 3,    1'b0, CHK_PREDICT, NO_POINT},
        // zero a: straight down the y axis in region two
        '{ROW_REQ,     0,    1'b1, CHK_FIXED,   '{11'd0, 11'd2, 1'b1, 1'b0}},
        '{ROW_REQ,     0,    1'b0, CHK_FIXED,   '{11'd0, 11'd1, 1'b1, 1'b0}},
        '{ROW_REQ,     0,    1'b0, CHK_FIXED,   '{11'd0, 11'd0, 1'b1, 1'b1}},
        '{ROW_REQ,     0,    1'b0, CHK_NONE,    NO_POINT},  // advance after the end
        '{ROW_WRITE_A, 2047, 1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_WRITE_B, 2047, 1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b1, CHK_FIXED,   '{11'd0, 11'd2047, 1'b0, 1'b0}},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        // new axes mid-walk: the walk keeps its latched squares
        '{ROW_WRITE_A, 3,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_WRITE_B, 2,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b1, CHK_FIXED,   '{11'd0, 11'd2, 1'b0, 1'b0}},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},  // crosses into region two
        '{ROW_REQ,     0,    1'b0, CHK_NONE,    NO_POINT},
        '{ROW_WRITE_B, 0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b1, CHK_NONE,    NO_POINT},
        // tall and thin, then wide and flat
        '{ROW_WRITE_A, 1,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_WRITE_B, 2047, 1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b1, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_WRITE_A, 2047, 1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_WRITE_B, 1,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b1, CHK_FIXED,   '{11'd0, 11'd1, 1'b0, 1'b0}},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT},
        '{ROW_REQ,     0,    1'b0, CHK_PREDICT, NO_POINT}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [CFG_DW-1:0]    pwdata;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    mew_req_if req_if ();
    mew_pt_if  pt_if ();

    midpoint_ellipse_quadrant_walker_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_pt    (pt_if)
    );

    always #2 i_clk = ~i_clk;

    // expected points, oldest first
    t_point pending_points [$];
    int     mismatches    = 0;
    int     counted_items = 0;
    int     stall_cycles  = 0;
    int     tx_idle_pct   = 0;
    int     rx_stall_pct  = 0;

    // walker state as the block should hold it
    t_coord      cfg_semi_a = '0;
    t_coord      cfg_semi_b = '0;
    t_coord      walk_x = '0;
    t_coord      walk_y = '0;
    logic [63:0] walk_dec = '0;
    logic [63:0] walk_a_sq = '0;
    logic [63:0] walk_b_sq = '0;
    logic        walk_in_region2 = 1'b0;
    logic        walk_finished = 1'b1;

    // One request through the midpoint walk; returns 1 when a point comes out.
    // Decision variables are four times the textbook ones, 64-bit two's complement.
    function automatic bit next_ellipse_point(input bit restart, output t_point pt);
        logic [63:0] x, y, tx, ty, ystep;
        pt = NO_POINT;
        if (restart) begin
            walk_a_sq       = 64'(cfg_semi_a) * 64'(cfg_semi_a);
            walk_b_sq       = 64'(cfg_semi_b) * 64'(cfg_semi_b);
            walk_x          = '0;
            walk_y          = cfg_semi_b;
            walk_dec        = 4 * walk_b_sq + walk_a_sq - 4 * walk_a_sq * 64'(cfg_semi_b);
            walk_in_region2 = 1'b0;
            walk_finished   = 1'b0;
        end
        if (walk_finished)
            return 1'b0;
        x = 64'(walk_x);
        y = 64'(walk_y);
        if (!walk_in_region2) begin
            // region one: emit, then step
            if (y != 0 && 2 * walk_b_sq * (x + 1) < walk_a_sq * (2 * y - 1)) begin
                pt = '{x: walk_x, y: walk_y, region2: 1'b0, last: 1'b0};
                if (walk_dec[63]) begin
                    walk_dec = walk_dec + 4 * walk_b_sq * (2 * x + 3);
                end else begin
                    walk_dec = walk_dec + 4 * walk_b_sq * (2 * x + 3)
                             + 8 * walk_a_sq - 8 * walk_a_sq * y;
                    walk_y   = walk_y - t_coord'(1);
                end
                walk_x = walk_x + t_coord'(1);
                return 1'b1;
            end
            // slope got steep: region two start uses squared terms
            tx = 2 * x + 1;
            ty = (y == 0) ? 64'd1 : y - 1;
            walk_dec = walk_b_sq * tx * tx + 4 * walk_a_sq * ty * ty
                     - 4 * walk_a_sq * walk_b_sq;
            walk_in_region2 = 1'b1;
        end
        if (y == 0) begin
            walk_finished = 1'b1;
            return 1'b0;
        end
        // region two: step toward y = 0, then emit
        ystep = 12 * walk_a_sq - 8 * walk_a_sq * y;
        if (walk_dec[63]) begin
            walk_dec = walk_dec + 4 * walk_b_sq * (2 * x + 2) + ystep;
            walk_x   = walk_x + t_coord'(1);
        end else begin
            walk_dec = walk_dec + ystep;
        end
        walk_y = walk_y - t_coord'(1);
        if (walk_y == '0)
            walk_finished = 1'b1;
        pt = '{x: walk_x, y: walk_y, region2: 1'b1, last: (walk_y == '0)};
        return 1'b1;
    endfunction

    // mostly small axes, a few medium, rare extremes
    function automatic t_coord pick_axis();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return '1;
        if (r < 5)
            return t_coord'($urandom_range(2047));
        if (r < 15)
            return t_coord'($urandom_range(150, 25));
        return t_coord'($urandom_range(24));
    endfunction

    // one request beat; the expectation is queued at the accepting edge
    task automatic send_request(input bit restart, input t_check_kind chk,
                                input t_point fixed_pt);
        t_point pt;
        bit     got;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid   = 1'b0;
            req_if.restart = 1'($urandom_range(1));
            @(negedge i_clk);
        end
        req_if.valid   = 1'b1;
        req_if.restart = restart;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        got = next_ellipse_point(restart, pt);
        if (restart || got)
            counted_items++;
        case (chk)
            CHK_PREDICT: if (got) pending_points.push_back(pt);
            CHK_FIXED:   pending_points.push_back(fixed_pt);
            default:     ;
        endcase
    endtask

    // stop sending, let every expected point arrive, then let the block go quiet
    task automatic drain_points();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a readback of the same register
    task automatic write_axis(input t_reg_idx idx, input t_coord value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = CFG_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (idx == REG_SEMI_A)
            cfg_semi_a = value;
        else
            cfg_semi_b = value;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== CFG_DW'(value)) begin
            $error("prdata (reg %0d): expected %0d, got %0d", idx, value, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // point receiver with random back-pressure
    initial begin
        pt_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pt_if.ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // check each point beat against the oldest expectation
    always @(posedge i_clk) begin : point_check
        t_point want;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected point beat: x=%0d y=%0d", pt_if.point_x, pt_if.point_y);
                mismatches++;
            end else begin
                want = pending_points.pop_front();
                if (pt_if.point_x !== want.x) begin
                    $error("point_x: expected %0d, got %0d", want.x, pt_if.point_x);
                    mismatches++;
                end
                if (pt_if.point_y !== want.y) begin
                    $error("point_y: expected %0d, got %0d", want.y, pt_if.point_y);
                    mismatches++;
                end
                if (pt_if.in_second_region !== want.region2) begin
                    $error("in_second_region: expected %0d, got %0d",
                           want.region2, pt_if.in_second_region);
                    mismatches++;
                end
                if (pt_if.last_point !== want.last) begin
                    $error("last_point: expected %0d, got %0d", want.last, pt_if.last_point);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles without any beat or register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (pt_if.valid && pt_if.ready)
                || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles, %0d points outstanding",
                   stall_cycles, pending_points.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int     walks;
        int     steps;
        int     cap;
        int     phase_start;
        t_coord axis_a;
        t_coord axis_b;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE_A: begin
                    drain_points();
                    write_axis(REG_SEMI_A, t_coord'(plan[i].value));
                end
                ROW_WRITE_B: begin
                    drain_points();
                    write_axis(REG_SEMI_B, t_coord'(plan[i].value));
                end
                default: send_request(plan[i].restart, plan[i].chk, plan[i].pt);
            endcase
        end

        // random walks, one idling pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = TX_IDLE_PCT[ph];
            rx_stall_pct = RX_STALL_PCT[ph];
            phase_start = counted_items;
            while (counted_items - phase_start < ITEMS_PER_PHASE) begin
                axis_a = pick_axis();
                axis_b = pick_axis();
                drain_points();
                write_axis(REG_SEMI_A, axis_a);
                write_axis(REG_SEMI_B, axis_b);
                // long quadrants are cut short by the next restart
                cap = (axis_a > 150 || axis_b > 150) ? $urandom_range(40, 4) : 100000;
                walks = $urandom_range(3, 1);
                repeat (walks) begin
                    send_request(1'b1, CHK_PREDICT, NO_POINT);
                    steps = 0;
                    while (!walk_finished && steps < cap) begin
                        send_request($urandom_range(99) < 3, CHK_PREDICT, NO_POINT);
                        steps++;
                        if ($urandom_range(99) < 2)
                            drain_points();
                    end
                    repeat ($urandom_range(2)) send_request(1'b0, CHK_PREDICT, NO_POINT);
                end
            end
        end

        drain_points();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
